>>> design/aabb_pkg.sv
// aabb_pkg: shared types and constants for the slide collision response block
// no dependencies

package aabb_pkg;

   // number of correcting flags, one per entity
   localparam int ENTITY_COUNT = 256;

   // configuration register indexes
   localparam logic [2:0] CSR_OBSTACLE_X      = 3'd0;
   localparam logic [2:0] CSR_OBSTACLE_Y      = 3'd1;
   localparam logic [2:0] CSR_OBSTACLE_LEFT   = 3'd2;
   localparam logic [2:0] CSR_OBSTACLE_TOP    = 3'd3;
   localparam logic [2:0] CSR_OBSTACLE_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_OBSTACLE_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_PUSH_MARGIN     = 3'd6;

   // push side codes
   localparam logic [1:0] PUSH_LEFT   = 2'd0;
   localparam logic [1:0] PUSH_RIGHT  = 2'd1;
   localparam logic [1:0] PUSH_TOP    = 2'd2;
   localparam logic [1:0] PUSH_BOTTOM = 2'd3;

   // classified work item passed from front to back
   typedef struct packed {
      logic               apply;     // moving into the obstacle
      logic               do_push;   // flag was clear, push out
      logic               x_axis;    // normal on x
      logic [1:0]         side;      // push side
      logic signed [33:0] push_amt;  // overlap to add or subtract
      logic signed [31:0] tan_v;     // tangential velocity
      logic [63:0]        mag2;      // vx^2 + vy^2
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } work_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) return 32'sh7fffffff;
      else if (v < -35'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

>>> design/aabb_front.sv
// aabb_front: accepts items, picks the normal, reads and updates the
// correcting flags, computes overlaps and squares; depends on aabb_pkg

module aabb_front import aabb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         entity_index,
   input  logic signed [31:0] vel_x,
   input  logic signed [31:0] vel_y,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] box_left,
   input  logic signed [31:0] box_top,
   input  logic [30:0]        box_width,
   input  logic [30:0]        box_height,
   input  logic signed [31:0] obstacle_x,
   input  logic signed [31:0] obstacle_y,
   input  logic signed [31:0] obstacle_left,
   input  logic signed [31:0] obstacle_top,
   input  logic [30:0]        obstacle_width,
   input  logic [30:0]        obstacle_height,
   output logic               out_valid,
   input  logic               out_ready,
   output work_type           out_work
);

   localparam int IW = $clog2(ENTITY_COUNT);

   // stage 1 registers: decisions, flag read and magnitudes
   logic               s1_valid_ff, s1_valid_in;
   work_type           s1_ff, s1_in;
   logic [IW-1:0]      s1_idx_ff;
   logic               rd_flag_ff;
   logic               fwd_ff, fwd_in;
   logic               fwd_val_ff;
   logic [31:0]        ax_ff, ay_ff;
   // stage 2 registers: resolved push decision and squares
   logic [63:0]        sx_ff, sy_ff;
   logic               s2_valid_ff, s2_valid_in;
   work_type           s2_ff, s2_in;
   // correcting flags and the clearing pass after reset
   logic               flags_mem [ENTITY_COUNT];
   logic               clearing_ff, clearing_in;
   logic [IW-1:0]      clr_ff, clr_in;

   logic [IW-1:0]      idx;
   logic signed [32:0] dx, dy, adx, ady;
   logic               x_axis, dot_neg;
   logic signed [33:0] ovl, ovr, ovt, ovb;
   logic [1:0]         side;
   logic signed [33:0] amt;
   logic               adv2, adv1, accept, advance1, flag_now;

   assign adv2      = !s2_valid_ff || out_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign in_ready  = adv1 && !clearing_ff;
   assign accept    = in_valid && in_ready;
   assign advance1  = s1_valid_ff && adv2;
   assign out_valid = s2_valid_ff;

   // queue entry with the sum of squares
   always_comb begin
      out_work      = s2_ff;
      out_work.mag2 = sx_ff + sy_ff;
   end

   // classify the transaction
   always_comb begin
      idx    = entity_index[IW-1:0];
      dx     = 33'(pos_x) - 33'(obstacle_x);
      dy     = 33'(pos_y) - 33'(obstacle_y);
      adx    = dx[32] ? -dx : dx;
      ady    = dy[32] ? -dy : dy;
      x_axis = adx > ady;
      if (x_axis) dot_neg = (dx > 0) ? vel_x[31] : (vel_x > 0);
      else        dot_neg = (dy > 0) ? vel_y[31] : (vel_y > 0);
      ovl = 34'(box_left) + 34'(box_width) - 34'(obstacle_left);
      ovr = 34'(obstacle_left) + 34'(obstacle_width) - 34'(box_left);
      ovt = 34'(box_top) + 34'(box_height) - 34'(obstacle_top);
      ovb = 34'(obstacle_top) + 34'(obstacle_height) - 34'(box_top);
      if (ovl < ovr && ovl < ovt && ovl < ovb) begin
         side = PUSH_LEFT;   amt = ovl;
      end else if (ovr < ovl && ovr < ovt && ovr < ovb) begin
         side = PUSH_RIGHT;  amt = ovr;
      end else if (ovt < ovb) begin
         side = PUSH_TOP;    amt = ovt;
      end else begin
         side = PUSH_BOTTOM; amt = ovb;
      end
      s1_in          = '0;
      s1_in.apply    = dot_neg;
      s1_in.x_axis   = x_axis;
      s1_in.side     = side;
      s1_in.push_amt = amt;
      s1_in.tan_v    = x_axis ? vel_y : vel_x;
      s1_in.vel_x    = vel_x;
      s1_in.vel_y    = vel_y;
      s1_in.pos_x    = pos_x;
      s1_in.pos_y    = pos_y;
      // flag written by the item ahead in the same cycle is forwarded
      fwd_in   = advance1 && (s1_idx_ff == idx);
      flag_now = fwd_ff ? fwd_val_ff : rd_flag_ff;
      s2_in         = s1_ff;
      s2_in.do_push = s1_ff.apply && !flag_now;
      s1_valid_in = adv1 ? accept : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      clr_in      = clearing_ff ? clr_ff + 1'b1 : clr_ff;
      clearing_in = clearing_ff && (clr_ff != IW'(ENTITY_COUNT - 1));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   // flag memory: clearing pass, write on leaving stage 1, registered read
   always_ff @(posedge clock) begin
      if (clearing_ff) flags_mem[clr_ff] <= 1'b0;
      else if (advance1) flags_mem[s1_idx_ff] <= s1_ff.apply;
      if (accept) rd_flag_ff <= flags_mem[idx];
   end

   // payload: magnitudes, then squares registered before the sum
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff      <= s1_in;
         s1_idx_ff  <= idx;
         fwd_ff     <= fwd_in;
         fwd_val_ff <= s1_ff.apply;
         ax_ff <= vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
         ay_ff <= vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
      end
      if (adv2) begin
         sx_ff <= 64'(ax_ff) * 64'(ax_ff);
         sy_ff <= 64'(ay_ff) * 64'(ay_ff);
         s2_ff <= s2_in;
      end
   end

endmodule

>>> design/aabb_queue.sv
// aabb_queue: small fifo between front and back
// depends on aabb_pkg

module aabb_queue import aabb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_work,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_work
);

   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   work_type   mem_ff [4];
   logic       push, pop;

   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign out_work  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // pointer update
   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_work;
   end

endmodule

>>> design/aabb_back.sv
// aabb_back: square root of the speed, slid velocity and push-out position
// depends on aabb_pkg

module aabb_back import aabb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  work_type           in_work,
   input  logic [30:0]        push_margin,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] new_vel_x,
   output logic signed [31:0] new_vel_y,
   output logic signed [31:0] new_pos_x,
   output logic signed [31:0] new_pos_y,
   output logic               response_applied
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [4:0]  step_ff, step_in;
   work_type    w_ff;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [65:0] trial;
   logic        out_valid_ff, out_valid_in;
   logic signed [31:0] nvx_ff, nvy_ff, npx_ff, npy_ff;
   logic        app_ff;
   logic signed [31:0] slid;
   logic signed [34:0] base, sum;

   assign in_ready   = st_ff == ST_IDLE;
   assign out_valid  = out_valid_ff;
   assign new_vel_x  = nvx_ff;
   assign new_vel_y  = nvy_ff;
   assign new_pos_x  = npx_ff;
   assign new_pos_y  = npy_ff;
   assign response_applied = app_ff;

   // restoring square root, one result bit per cycle
   always_comb begin
      trial   = '0;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      st_in   = st_ff;
      out_valid_in = out_valid_ff && !out_ready;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               st_in   = ST_ROOT;
               step_in = 5'd31;
               rem_in  = '0;
               root_in = '0;
            end
         end
         ST_ROOT: begin
            trial = {2'b0, rem_ff} + {2'b0, 64'(1) << (2 * step_ff)}
                    + ({34'b0, root_ff} << (step_ff + 5'd1));
            if (trial <= {2'b0, w_ff.mag2}) begin
               rem_in  = trial[63:0];
               root_in = root_ff | (32'd1 << step_ff);
            end
            if (step_ff == 5'd0) st_in = ST_DONE;
            else step_in = step_ff - 5'd1;
         end
         ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // slid velocity and pushed position
   always_comb begin
      if (w_ff.tan_v > 0) slid = sat32(35'(root_ff));
      else if (w_ff.tan_v < 0) slid = sat32(-35'(root_ff));
      else slid = '0;
      case (w_ff.side)
         PUSH_LEFT:  base = 35'(w_ff.pos_x) - 35'(w_ff.push_amt);
         PUSH_RIGHT: base = 35'(w_ff.pos_x) + 35'(w_ff.push_amt);
         PUSH_TOP:   base = 35'(w_ff.pos_y) - 35'(w_ff.push_amt);
         default:    base = 35'(w_ff.pos_y) + 35'(w_ff.push_amt);
      endcase
      sum = base + 35'(push_margin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (st_ff == ST_IDLE && in_valid) w_ff <= in_work;
      if (st_ff == ST_DONE && (!out_valid_ff || out_ready)) begin
         app_ff <= w_ff.apply;
         nvx_ff <= w_ff.vel_x; nvy_ff <= w_ff.vel_y;
         npx_ff <= w_ff.pos_x; npy_ff <= w_ff.pos_y;
         if (w_ff.apply) begin
            nvx_ff <= w_ff.x_axis ? 32'sd0 : slid;
            nvy_ff <= w_ff.x_axis ? slid : 32'sd0;
            if (w_ff.do_push) begin
               if (w_ff.side == PUSH_LEFT || w_ff.side == PUSH_RIGHT)
                  npx_ff <= sat32(sum);
               else
                  npy_ff <= sat32(sum);
            end
         end
      end
   end

endmodule

>>> design/aabb_slide_collision_response.sv
// aabb_slide_collision_response: top level, csr bank and channel wiring
// depends on aabb_pkg, aabb_front, aabb_queue, aabb_back
//
// channel  dir  fields (low bit up)
// req      in   tdata: vel_x, vel_y, pos_x, pos_y, box_left, box_top,
//                      box_width, box_height; tuser: entity_index
// rsp      out  tdata: new_vel_x, new_vel_y, new_pos_x, new_pos_y,
//                      response_applied
// csr      in   index 3 bits, data 32 bits
//
// a result passes through two front stages, the queue, a load into the back unit,
// 32 square root steps and an output register after its transaction is accepted.
// the back unit takes no new transaction until it is done with the last one.
// after reset a clearing pass over all 256 correcting flags holds req_tready low.
// the front and the four-entry queue keep taking items while the back computes;
// a stalled rsp holds the back in its done state.

module aabb_slide_collision_response import aabb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,   // vel_x, vel_y, pos_x, pos_y, box_left, box_top,
                                     // box_width, box_height, zero pad
   input  logic [7:0]   req_tuser,   // entity_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // new_vel_x, new_vel_y, new_pos_x, new_pos_y,
                                     // response_applied, zero pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic signed [31:0] ox_ff, oy_ff, ol_ff, ot_ff;
   logic [30:0]        ow_ff, oh_ff, margin_ff;
   logic               f_valid, f_ready, b_valid, b_ready;
   work_type           f_work, b_work;
   logic signed [31:0] nvx, nvy, npx, npy;
   logic               app;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; ol_ff <= '0; ot_ff <= '0;
         ow_ff <= '0; oh_ff <= '0; margin_ff <= 31'd6554;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OBSTACLE_X:      ox_ff <= csr_data;
            CSR_OBSTACLE_Y:      oy_ff <= csr_data;
            CSR_OBSTACLE_LEFT:   ol_ff <= csr_data;
            CSR_OBSTACLE_TOP:    ot_ff <= csr_data;
            CSR_OBSTACLE_WIDTH:  ow_ff <= csr_data[30:0];
            CSR_OBSTACLE_HEIGHT: oh_ff <= csr_data[30:0];
            CSR_PUSH_MARGIN:     margin_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   aabb_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .entity_index(req_tuser),
      .vel_x(req_tdata[31:0]), .vel_y(req_tdata[63:32]),
      .pos_x(req_tdata[95:64]), .pos_y(req_tdata[127:96]),
      .box_left(req_tdata[159:128]), .box_top(req_tdata[191:160]),
      .box_width(req_tdata[222:192]), .box_height(req_tdata[253:223]),
      .obstacle_x(ox_ff), .obstacle_y(oy_ff),
      .obstacle_left(ol_ff), .obstacle_top(ot_ff),
      .obstacle_width(ow_ff), .obstacle_height(oh_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   aabb_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(b_valid), .out_ready(b_ready), .out_work(b_work)
   );

   aabb_back u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_work(b_work),
      .push_margin(margin_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .new_vel_x(nvx), .new_vel_y(nvy), .new_pos_x(npx), .new_pos_y(npy),
      .response_applied(app)
   );

   assign rsp_tdata = {7'b0, app, npy, npx, nvy, nvx};

   // a held result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a slid velocity has a zero component on one axis
   a_slid_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[128] |-> (nvx == 32'sd0 || nvy == 32'sd0))
      else $error("slid velocity has two nonzero components");

endmodule
